// ----- rtl/core/ebba_pkg.sv -----
package ebba_pkg;

  localparam int CAPACITY   = 4096;
  localparam int NUM_BANKS  = 8;
  localparam int BANK_DEPTH = CAPACITY / NUM_BANKS;
  localparam int ROW_W      = $clog2(BANK_DEPTH);
  localparam int POS_W      = $clog2(CAPACITY + 1);
  localparam int DATA_W     = 64;
  localparam int OFF_W      = 14;
  localparam int NEWPOS_W   = 13;
  localparam int SUM_W      = ((POS_W > OFF_W) ? POS_W : OFF_W) + 2;

  localparam logic [1:0] BO_BIG = 2'd2;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_SEEK_REL = 2'd2,
    OP_SEEK_ABS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0] lo;
    logic [1:0] width_code;
    logic       big;
    logic       sign_extend;
  } lane_ctrl_t;

endpackage

// ----- rtl/core/endian_byte_buffer_access.sv -----
// Channel   Handshake          Payload
// input     start / busy       in_opcode, in_width_code, in_sign_extend,
//                              in_write_data, in_seek_offset
// result    out_valid strobe   out_read_data, out_ok, out_new_position
// config    cfg_wr_en          cfg_wr_data (byte order)
//
// An item passes through the accept cycle, in which the eight byte banks
// read the rows at the cursor, and the execute cycle, in which read data is
// assembled or write bytes land. busy is high during the execute cycle.
// The result strobe comes in the cycle after execute; the receiver cannot stall.
// After reset a clearing pass zeroes the store, one row of all banks a cycle,
// over CAPACITY/8 (512) rows with busy high.
module endian_byte_buffer_access (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic [1:0]                          in_width_code,
  input  logic                                in_sign_extend,
  input  logic [ebba_pkg::DATA_W-1:0]         in_write_data,
  input  logic signed [ebba_pkg::OFF_W-1:0]   in_seek_offset,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_wr_data,
  output logic                                out_valid,
  output logic [ebba_pkg::DATA_W-1:0]         out_read_data,
  output logic                                out_ok,
  output logic [ebba_pkg::NEWPOS_W-1:0]       out_new_position
);

  localparam int POS_W = ebba_pkg::POS_W;
  localparam int SUM_W = ebba_pkg::SUM_W;
  localparam int ROW_W = ebba_pkg::ROW_W;
  localparam int NB    = ebba_pkg::NUM_BANKS;

  ebba_pkg::state_t state_r, state_nxt;
  logic [ROW_W-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [POS_W-1:0]               cursor_r, cursor_nxt;
  logic [1:0]                     byte_order_r;

  ebba_pkg::op_t                  op_r;
  logic [1:0]                     wc_r;
  logic                           sext_r;
  logic [ebba_pkg::DATA_W-1:0]    wdata_r;
  logic signed [ebba_pkg::OFF_W-1:0] off_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [ebba_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                           out_ok_r, out_ok_nxt;

  logic                           accept;
  logic                           clearing;
  logic                           do_write;
  logic [3:0]                     n;
  logic                           in_range;
  logic signed [SUM_W-1:0]        cur_s, off_s, cap_s, target;

  ebba_pkg::lane_ctrl_t           lane_ctrl;
  logic [NB-1:0][7:0]             bank_rdata;
  logic [NB-1:0][7:0]             bank_wdata;
  logic [NB-1:0]                  lane_en;
  logic [ebba_pkg::DATA_W-1:0]    read_value;
  logic [NB-1:0][ROW_W-1:0]       row;

  assign accept   = start && !busy;
  assign clearing = (state_r == ebba_pkg::ST_CLEAR);
  assign n        = 4'd1 << wc_r;
  assign in_range = ({1'b0, cursor_r} + (POS_W+1)'(n)) <= (POS_W+1)'(ebba_pkg::CAPACITY);
  assign do_write = (state_r == ebba_pkg::ST_EXEC) && (op_r == ebba_pkg::OP_WRITE) && in_range;

  assign lane_ctrl.lo          = cursor_r[2:0];
  assign lane_ctrl.width_code  = wc_r;
  assign lane_ctrl.big         = (byte_order_r == ebba_pkg::BO_BIG);
  assign lane_ctrl.sign_extend = sext_r;

  // bank b holds the bytes whose address is b mod 8; banks below the cursor's
  // lane take the next row
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      row[b] = ROW_W'(cursor_r[POS_W-1:3] + (POS_W-3)'(3'(b) < cursor_r[2:0]));
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    ebba_bank_ram u_ram (
      .clk   (clk),
      .we    (clearing || (do_write && lane_en[b])),
      .addr  (clearing ? clr_cnt_r : row[b]),
      .wdata (clearing ? 8'h00 : bank_wdata[b]),
      .rdata (bank_rdata[b])
    );
  end

  ebba_byte_lanes u_lanes (
    .ctrl       (lane_ctrl),
    .write_data (wdata_r),
    .bank_rdata (bank_rdata),
    .bank_wdata (bank_wdata),
    .lane_en    (lane_en),
    .read_value (read_value)
  );

  // seek target in a signed word wide enough for cursor plus offset
  always_comb begin
    cur_s = $signed({{(SUM_W-POS_W){1'b0}}, cursor_r});
    off_s = $signed({{(SUM_W-ebba_pkg::OFF_W){off_r[ebba_pkg::OFF_W-1]}}, off_r});
    cap_s = $signed(SUM_W'(ebba_pkg::CAPACITY));
    if (op_r == ebba_pkg::OP_SEEK_REL) begin
      target = cur_s + off_s;
    end else if (off_s < 0) begin
      target = cap_s + off_s;
    end else begin
      target = off_s;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    busy          = 1'b1;
    case (state_r)
      ebba_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_W'(ebba_pkg::BANK_DEPTH - 1)) begin
          state_nxt = ebba_pkg::ST_IDLE;
        end
      end
      ebba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = ebba_pkg::ST_EXEC;
        end
      end
      ebba_pkg::ST_EXEC: begin
        state_nxt     = ebba_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_ok_nxt    = 1'b1;
        case (op_r)
          ebba_pkg::OP_READ, ebba_pkg::OP_WRITE: begin
            if (in_range) begin
              cursor_nxt = cursor_r + POS_W'(n);
              if (op_r == ebba_pkg::OP_READ) begin
                out_data_nxt = read_value;
              end
            end else begin
              out_ok_nxt = 1'b0;
            end
          end
          ebba_pkg::OP_SEEK_REL, ebba_pkg::OP_SEEK_ABS: begin
            if (target < 0) begin
              cursor_nxt = '0;
            end else if (target > cap_s - 1) begin
              cursor_nxt = POS_W'(ebba_pkg::CAPACITY - 1);
            end else begin
              cursor_nxt = POS_W'(target);
            end
          end
          default: cursor_nxt = cursor_r;
        endcase
      end
      default: state_nxt = ebba_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ebba_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      cursor_r     <= '0;
      byte_order_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        byte_order_r <= cfg_wr_data;
      end
    end
  end

  // hold the item for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= ebba_pkg::op_t'(in_opcode);
      wc_r    <= in_width_code;
      sext_r  <= in_sign_extend;
      wdata_r <= in_write_data;
      off_r   <= in_seek_offset;
    end
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_ok           = out_ok_r;
  assign out_new_position = ebba_pkg::NEWPOS_W'(cursor_r);

endmodule

// ----- rtl/core/ebba_bank_ram.sv -----
module ebba_bank_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ebba_pkg::ROW_W-1:0] addr,
  input  logic [7:0]                 wdata,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [ebba_pkg::BANK_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ebba_byte_lanes.sv -----
module ebba_byte_lanes (
  input  ebba_pkg::lane_ctrl_t                     ctrl,
  input  logic [ebba_pkg::DATA_W-1:0]              write_data,
  input  logic [ebba_pkg::NUM_BANKS-1:0][7:0]      bank_rdata,
  output logic [ebba_pkg::NUM_BANKS-1:0][7:0]      bank_wdata,
  output logic [ebba_pkg::NUM_BANKS-1:0]           lane_en,
  output logic [ebba_pkg::DATA_W-1:0]              read_value
);

  logic [3:0]                                n;
  logic [ebba_pkg::NUM_BANKS-1:0][7:0]       ordered;
  logic [ebba_pkg::DATA_W-1:0]               raw;
  logic [2:0]                                src;
  logic [2:0]                                idx;

  always_comb begin
    n = 4'd1 << ctrl.width_code;
    // rotate bank outputs so that entry i is the byte at cursor + i
    for (int i = 0; i < ebba_pkg::NUM_BANKS; i++) begin
      ordered[i] = bank_rdata[3'(ctrl.lo + 3'(i))];
    end
    raw = '0;
    for (int j = 0; j < ebba_pkg::NUM_BANKS; j++) begin
      src = ctrl.big ? 3'(n - 4'd1 - 4'(j)) : 3'(j);
      raw[j*8 +: 8] = (4'(j) < n) ? ordered[src] : 8'h00;
    end
    read_value = raw;
    if (ctrl.sign_extend) begin
      case (ctrl.width_code)
        2'd0: if (raw[7])  read_value = {{56{1'b1}}, raw[7:0]};
        2'd1: if (raw[15]) read_value = {{48{1'b1}}, raw[15:0]};
        2'd2: if (raw[31]) read_value = {{32{1'b1}}, raw[31:0]};
        default: read_value = raw;
      endcase
    end
    // scatter: bank b holds access byte (b - lo) mod 8
    for (int b = 0; b < ebba_pkg::NUM_BANKS; b++) begin
      idx = 3'(3'(b) - ctrl.lo);
      lane_en[b] = {1'b0, idx} < n;
      src = ctrl.big ? 3'(n - 4'd1 - {1'b0, idx}) : idx;
      bank_wdata[b] = write_data[{src, 3'b000} +: 8];
    end
  end

endmodule

// ----- tb/endian_byte_buffer_access_tb.sv -----
module endian_byte_buffer_access_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebba_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    op_t                      op;
    logic [1:0]               wc;
    logic                     sx;
    logic [DATA_W-1:0]        wd;
    logic signed [OFF_W-1:0]  off;
  } access_t;

  typedef struct {
    logic [DATA_W-1:0]   rd;
    logic                ok;
    logic [NEWPOS_W-1:0] pos;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = 2'd0;
  logic [1:0] in_width_code = 2'd0;
  logic in_sign_extend = 1'b0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic signed [OFF_W-1:0] in_seek_offset = '0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic out_valid;
  logic [DATA_W-1:0] out_read_data;
  logic out_ok;
  logic [NEWPOS_W-1:0] out_new_position;

  access_t access_q[$];
  reply_t  reply_q[$];
  access_t cur;
  reply_t  want;

  logic [7:0] shadow_mem [CAPACITY];
  int shadow_cursor;
  logic [1:0] shadow_order;

  int idle_pct = 0;
  int calm_left = 0;
  int errors = 0;
  int cycles = 0;

  endian_byte_buffer_access DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_width_code    (in_width_code),
    .in_sign_extend   (in_sign_extend),
    .in_write_data    (in_write_data),
    .in_seek_offset   (in_seek_offset),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_ok           (out_ok),
    .out_new_position (out_new_position)
  );

  always #5 clk = ~clk;

  // Apply one access to the shadow store and queue the reply it gives.
  task automatic do_access(input access_t a);
    int n;
    int tgt;
    logic big;
    reply_t r;
    n = 1 << a.wc;
    big = (shadow_order == BO_BIG);
    r.rd = '0;
    r.ok = 1'b1;
    case (a.op)
      OP_READ: begin
        if (shadow_cursor + n <= CAPACITY) begin
          for (int i = 0; i < n; i++) begin
            if (big) begin
              r.rd = {r.rd[DATA_W-9:0], shadow_mem[shadow_cursor + i]};
            end else begin
              r.rd[8*i +: 8] = shadow_mem[shadow_cursor + i];
            end
          end
          if (a.sx && n < 8 && r.rd[8*n-1]) begin
            r.rd = r.rd | ({DATA_W{1'b1}} << (8*n));
          end
          shadow_cursor += n;
        end else begin
          r.ok = 1'b0;
        end
      end
      OP_WRITE: begin
        if (shadow_cursor + n <= CAPACITY) begin
          for (int i = 0; i < n; i++) begin
            shadow_mem[shadow_cursor + i] = big ? a.wd[8*(n-1-i) +: 8] : a.wd[8*i +: 8];
          end
          shadow_cursor += n;
        end else begin
          r.ok = 1'b0;
        end
      end
      default: begin
        if (a.op == OP_SEEK_REL) begin
          tgt = shadow_cursor + int'(a.off);
        end else begin
          tgt = (a.off < 0) ? CAPACITY + int'(a.off) : int'(a.off);
        end
        if (tgt < 0) begin
          tgt = 0;
        end else if (tgt > CAPACITY - 1) begin
          tgt = CAPACITY - 1;
        end
        shadow_cursor = tgt;
      end
    endcase
    r.pos = shadow_cursor[NEWPOS_W-1:0];
    reply_q.push_back(r);
  endtask

  function automatic bit sender_pause();
    if (calm_left > 0) begin
      calm_left--;
      return 1'b0;
    end
    // Drop into a short run without gaps now and then.
    if ($urandom_range(199) == 0) calm_left = 40;
    return $urandom_range(99) < idle_pct;
  endfunction

  function automatic access_t mk(op_t op, int wc, bit sx, logic [DATA_W-1:0] wd, int off);
    access_t a;
    a.op = op;
    a.wc = wc[1:0];
    a.sx = sx;
    a.wd = wd;
    a.off = off[OFF_W-1:0];
    return a;
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int pick;
    pick = $urandom_range(99);
    a.wc = 2'($urandom_range(3));
    a.sx = 1'($urandom_range(1));
    a.wd = {$urandom, $urandom};
    a.off = OFF_W'($urandom_range(16383));
    if (pick < 36) begin
      a.op = OP_READ;
    end else if (pick < 72) begin
      a.op = OP_WRITE;
    end else if (pick < 86) begin
      a.op = OP_SEEK_REL;
      if ($urandom_range(9) < 7) a.off = OFF_W'(int'($urandom_range(32)) - 16);
    end else begin
      a.op = OP_SEEK_ABS;
      pick = $urandom_range(9);
      // Keep most traffic in a small window at the start or near the end.
      if (pick < 4) begin
        a.off = OFF_W'($urandom_range(63));
      end else if (pick < 7) begin
        a.off = OFF_W'(-int'($urandom_range(40, 1)));
      end
    end
    return a;
  endfunction

  // Driver: hold an item until it transfers, then present the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur = access_q.pop_front();
        do_access(cur);
      end
      if (!start || !busy) begin
        if (access_q.size() != 0 && !sender_pause()) begin
          start          <= 1'b1;
          in_opcode      <= access_q[0].op;
          in_width_code  <= access_q[0].wc;
          in_sign_extend <= access_q[0].sx;
          in_write_data  <= access_q[0].wd;
          in_seek_offset <= access_q[0].off;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding reply.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result with none outstanding: data %h ok %b pos %0d", $time,
                 out_read_data, out_ok, out_new_position);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_read_data !== want.rd) begin
          $display("%0t: read_data expected %h actual %h", $time, want.rd, out_read_data);
          errors++;
        end
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, out_ok);
          errors++;
        end
        if (out_new_position !== want.pos) begin
          $display("%0t: new_position expected %0d actual %0d", $time, want.pos,
                   out_new_position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (access_q.size() != 0 || reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_order(input logic [1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    shadow_order = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [1:0] order, input int pct, input int count);
    wait_drained();
    set_order(order);
    idle_pct = pct;
    repeat (count) access_q.push_back(rand_access());
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) shadow_mem[i] = 8'h00;
    shadow_cursor = 0;
    shadow_order = 2'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Hold off until the clearing pass after reset is done.
    while (busy !== 1'b0) @(negedge clk);

    set_order(BO_BIG);
    idle_pct = 0;
    access_q.push_back(mk(OP_READ,     3, 0, '0, 0));
    access_q.push_back(mk(OP_WRITE,    3, 0, 64'h0123_4567_89AB_CDEF, 0));
    access_q.push_back(mk(OP_SEEK_ABS, 0, 0, '0, 0));
    access_q.push_back(mk(OP_READ,     3, 0, '0, 0));
    access_q.push_back(mk(OP_SEEK_ABS, 0, 0, '0, 0));
    access_q.push_back(mk(OP_READ,     2, 1, '0, 0));
    access_q.push_back(mk(OP_READ,     1, 1, '0, 0));
    access_q.push_back(mk(OP_READ,     0, 1, '0, 0));
    access_q.push_back(mk(OP_READ,     0, 0, '0, 0));
    access_q.push_back(mk(OP_WRITE,    1, 0, 64'hFFFF_FFFF_FFFF_8000, 0));
    access_q.push_back(mk(OP_SEEK_REL, 0, 0, '0, -2));
    access_q.push_back(mk(OP_READ,     1, 1, '0, 0));
    access_q.push_back(mk(OP_SEEK_ABS, 0, 0, '0, 0));
    access_q.push_back(mk(OP_READ,     3, 1, '0, 0));
    access_q.push_back(mk(OP_SEEK_ABS, 0, 0, '0, 8191));
    access_q.push_back(mk(OP_READ,     1, 0, '0, 0));
    access_q.push_back(mk(OP_WRITE,    1, 0, '1, 0));
    access_q.push_back(mk(OP_WRITE,    0, 0, 64'hAA, 0));
    access_q.push_back(mk(OP_READ,     0, 1, '0, 0));
    access_q.push_back(mk(OP_SEEK_REL, 0, 0, '0, 8191));
    access_q.push_back(mk(OP_SEEK_ABS, 0, 0, '0, -8192));
    access_q.push_back(mk(OP_SEEK_ABS, 0, 0, '0, -1));
    access_q.push_back(mk(OP_SEEK_REL, 3, 1, '1, -8192));
    access_q.push_back(mk(OP_SEEK_ABS, 2, 1, '1, -8));
    access_q.push_back(mk(OP_WRITE,    3, 0, 64'hFEDC_BA98_7654_3210, 0));
    access_q.push_back(mk(OP_WRITE,    2, 0, '1, 0));

    run_phase(2'd0, 0, 400);
    run_phase(2'd1, 68, 400);
    run_phase(2'd2, 0, 350);
    run_phase(2'd3, 31, 350);
    run_phase(BO_BIG, 68, 350);

    wait_drained();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
